// ===== hdl/asd_pkg.sv =====
// Shared types and constants of the accelerometer shake detector.
package asd_pkg;

  // Consecutive read failures that disable the detector.
  localparam logic [7:0] FailLimit = 8'd10;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgDetectEnable  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgShakeThresh   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinShakeMs    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgQuietMs       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCooldownMs    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMinIntervalMs = 3'd5;
  localparam int unsigned CfgDataW = 17;

  // Register reset values.
  localparam logic [16:0] ShakeThreshRst   = 17'd3000;
  localparam logic [15:0] MinShakeMsRst    = 16'd100;
  localparam logic [15:0] QuietMsRst       = 16'd300;
  localparam logic [15:0] CooldownMsRst    = 16'd1000;
  localparam logic [15:0] MinIntervalMsRst = 16'd20;

  // Detection phases.
  localparam logic [1:0] PhaseIdle  = 2'd0;
  localparam logic [1:0] PhaseShake = 2'd1;
  localparam logic [1:0] PhaseQuiet = 2'd2;

  // One detection request as held in the input register.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] x_read_a;
    logic signed [15:0] x_read_b;
    logic signed [15:0] x_read_c;
    logic signed [15:0] y_read_a;
    logic signed [15:0] y_read_b;
    logic signed [15:0] y_read_c;
    logic signed [15:0] z_read_a;
    logic signed [15:0] z_read_b;
    logic signed [15:0] z_read_c;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    logic               shake_event;
    logic               ready_res;
    logic signed [15:0] filtered_x;
    logic signed [15:0] filtered_y;
    logic signed [15:0] filtered_z;
    logic [1:0]         shake_phase;
  } res_t;

endpackage

// ===== hdl/asd_req_if.sv =====
// Request channel of the shake detector: three readings per axis and a timestamp.
interface asd_req_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic signed [15:0] x_read_a;
  logic signed [15:0] x_read_b;
  logic signed [15:0] x_read_c;
  logic signed [15:0] y_read_a;
  logic signed [15:0] y_read_b;
  logic signed [15:0] y_read_c;
  logic signed [15:0] z_read_a;
  logic signed [15:0] z_read_b;
  logic signed [15:0] z_read_c;

  modport source (
    output valid, now_ms, x_read_a, x_read_b, x_read_c,
           y_read_a, y_read_b, y_read_c, z_read_a, z_read_b, z_read_c,
    input  ready
  );
  modport sink (
    input  valid, now_ms, x_read_a, x_read_b, x_read_c,
           y_read_a, y_read_b, y_read_c, z_read_a, z_read_b, z_read_c,
    output ready
  );
endinterface

// ===== hdl/asd_res_if.sv =====
// Result channel of the shake detector: event flag, status and filtered sample.
interface asd_res_if;
  logic               valid;
  logic               ready;
  logic               shake_event;
  logic               ready_res;
  logic signed [15:0] filtered_x;
  logic signed [15:0] filtered_y;
  logic signed [15:0] filtered_z;
  logic [1:0]         shake_phase;

  modport source (
    output valid, shake_event, ready_res, filtered_x, filtered_y, filtered_z,
           shake_phase,
    input  ready
  );
  modport sink (
    input  valid, shake_event, ready_res, filtered_x, filtered_y, filtered_z,
           shake_phase,
    output ready
  );
endinterface

// ===== hdl/asd_axis.sv =====
// One axis: median of three readings and wrapped absolute delta from the baseline.
module asd_axis (
  input  logic signed [15:0] read_a_i,
  input  logic signed [15:0] read_b_i,
  input  logic signed [15:0] read_c_i,
  input  logic [15:0]        base_i,
  output logic signed [15:0] med_o,
  output logic [16:0]        mag_o
);

  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic [15:0]        delta;

  // median = clamp(c, min(a,b), max(a,b))
  always_comb begin
    if (read_a_i > read_b_i) begin
      lo = read_b_i;
      hi = read_a_i;
    end else begin
      lo = read_a_i;
      hi = read_b_i;
    end
    if (read_c_i < lo) begin
      med_o = lo;
    end else if (read_c_i > hi) begin
      med_o = hi;
    end else begin
      med_o = read_c_i;
    end
  end

  // delta wraps to 16 bits; magnitude of -32768 is 32768
  assign delta = 16'(med_o) - base_i;
  assign mag_o = {1'b0, delta[15] ? 16'(~delta + 16'd1) : delta};

endmodule

// ===== hdl/accel_shake_detector.sv =====
// Top level of the accelerometer shake detector.
//
// Usage: each request on req_i carries a millisecond timestamp and three raw
// signed readings per axis. The block takes the per-axis median, tracks read
// failures, compares the summed baseline deltas against the threshold register
// and runs the idle / shaking / waiting-quiet phase machine. Every request
// gives exactly one result on res_o: event flag, status, last valid sample, phase.
// The first request after reset only loads the baseline.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write
// only while no request is in flight.
// Flow: a request is taken into the input register; its result is computed
// from there and registered when the result register is free or its result is taken.
// Throughput: one request per cycle while res_o does not stall; the state update
// from the input register to the result register sets that rate.
// Reset: all detector state clears, registers take their defaults, both
// channels go empty. When res_o stalls, the result register holds and the
// input register fills; req_i.ready then drops until the result is taken.
module accel_shake_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asd_pkg::CfgDataW-1:0] cfg_wdata_i,
  asd_req_if.sink                      req_i,
  asd_res_if.source                    res_o
);

  // Configuration registers
  logic        detect_enable_q;
  logic [16:0] shake_thresh_q;
  logic [15:0] min_shake_ms_q;
  logic [15:0] quiet_ms_q;
  logic [15:0] cooldown_ms_q;
  logic [15:0] min_interval_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_enable_q   <= 1'b1;
      shake_thresh_q    <= asd_pkg::ShakeThreshRst;
      min_shake_ms_q    <= asd_pkg::MinShakeMsRst;
      quiet_ms_q        <= asd_pkg::QuietMsRst;
      cooldown_ms_q     <= asd_pkg::CooldownMsRst;
      min_interval_ms_q <= asd_pkg::MinIntervalMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asd_pkg::CfgDetectEnable:  detect_enable_q   <= cfg_wdata_i[0];
        asd_pkg::CfgShakeThresh:   shake_thresh_q    <= cfg_wdata_i;
        asd_pkg::CfgMinShakeMs:    min_shake_ms_q    <= cfg_wdata_i[15:0];
        asd_pkg::CfgQuietMs:       quiet_ms_q        <= cfg_wdata_i[15:0];
        asd_pkg::CfgCooldownMs:    cooldown_ms_q     <= cfg_wdata_i[15:0];
        asd_pkg::CfgMinIntervalMs: min_interval_ms_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register advances when the result register is free
  logic            in_valid_q;
  asd_pkg::req_t   in_q;
  logic            out_valid_q;
  asd_pkg::res_t   out_q;
  logic            step;

  assign step        = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{now_ms:   req_i.now_ms,
                x_read_a: req_i.x_read_a, x_read_b: req_i.x_read_b,
                x_read_c: req_i.x_read_c,
                y_read_a: req_i.y_read_a, y_read_b: req_i.y_read_b,
                y_read_c: req_i.y_read_c,
                z_read_a: req_i.z_read_a, z_read_b: req_i.z_read_b,
                z_read_c: req_i.z_read_c};
    end
  end

  // Detector state
  logic [15:0] base_x_q, base_y_q, base_z_q;
  logic [15:0] base_x_d, base_y_d, base_z_d;
  logic [15:0] valid_x_q, valid_y_q, valid_z_q;
  logic [15:0] valid_x_d, valid_y_d, valid_z_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] shake_start_q, shake_start_d;
  logic [31:0] quiet_start_q, quiet_start_d;
  logic [31:0] cool_stamp_q, cool_stamp_d;
  logic [31:0] last_read_q, last_read_d;
  logic [7:0]  fail_count_q, fail_count_d;
  logic        dead_q, dead_d;
  logic        init_q, init_d;
  logic        event_d;

  // Per-axis median and delta magnitude
  logic signed [15:0] med_x, med_y, med_z;
  logic [16:0]        mag_x, mag_y, mag_z;

  asd_axis u_axis_x (
    .read_a_i (in_q.x_read_a), .read_b_i (in_q.x_read_b), .read_c_i (in_q.x_read_c),
    .base_i   (base_x_q), .med_o (med_x), .mag_o (mag_x)
  );
  asd_axis u_axis_y (
    .read_a_i (in_q.y_read_a), .read_b_i (in_q.y_read_b), .read_c_i (in_q.y_read_c),
    .base_i   (base_y_q), .med_o (med_y), .mag_o (mag_y)
  );
  asd_axis u_axis_z (
    .read_a_i (in_q.z_read_a), .read_b_i (in_q.z_read_b), .read_c_i (in_q.z_read_c),
    .base_i   (base_z_q), .med_o (med_z), .mag_o (mag_z)
  );

  // Timing checks and shake level
  logic [31:0] now;
  logic        in_cooldown;
  logic        too_soon;
  logic        read_fail;
  logic [16:0] total;
  logic        shaking;
  logic [7:0]  fail_inc;

  assign now         = in_q.now_ms;
  assign in_cooldown = (cool_stamp_q != 32'd0) &&
                       ((now - cool_stamp_q) < {16'd0, cooldown_ms_q});
  assign too_soon    = (last_read_q != 32'd0) &&
                       ((now - last_read_q) < {16'd0, min_interval_ms_q});
  assign read_fail   = (med_x == 16'sd0) && (med_y == 16'sd0) && (med_z == 16'sd0);
  assign total       = mag_x + mag_y + mag_z;
  assign shaking     = total > shake_thresh_q;
  assign fail_inc    = (fail_count_q == 8'hFF) ? fail_count_q : fail_count_q + 8'd1;

  // Next state for one request
  always_comb begin
    base_x_d      = base_x_q;
    base_y_d      = base_y_q;
    base_z_d      = base_z_q;
    valid_x_d     = valid_x_q;
    valid_y_d     = valid_y_q;
    valid_z_d     = valid_z_q;
    phase_d       = phase_q;
    shake_start_d = shake_start_q;
    quiet_start_d = quiet_start_q;
    cool_stamp_d  = cool_stamp_q;
    last_read_d   = last_read_q;
    fail_count_d  = fail_count_q;
    dead_d        = dead_q;
    init_d        = init_q;
    event_d       = 1'b0;

    if (!init_q) begin
      // baseline load
      base_x_d     = 16'(med_x);
      base_y_d     = 16'(med_y);
      base_z_d     = 16'(med_z);
      valid_x_d    = 16'(med_x);
      valid_y_d    = 16'(med_y);
      valid_z_d    = 16'(med_z);
      cool_stamp_d = 32'd0;
      phase_d      = asd_pkg::PhaseIdle;
      fail_count_d = 8'd0;
      last_read_d  = 32'd0;
      init_d       = 1'b1;
    end else if (detect_enable_q && !dead_q && !in_cooldown && !too_soon) begin
      last_read_d = now;
      if (read_fail) begin
        fail_count_d = fail_inc;
        if (fail_inc >= asd_pkg::FailLimit) begin
          dead_d = 1'b1;
        end
      end else begin
        fail_count_d = 8'd0;
        valid_x_d    = 16'(med_x);
        valid_y_d    = 16'(med_y);
        valid_z_d    = 16'(med_z);
        base_x_d     = 16'(med_x);
        base_y_d     = 16'(med_y);
        base_z_d     = 16'(med_z);
        unique case (phase_q)
          asd_pkg::PhaseIdle: begin
            if (shaking) begin
              phase_d       = asd_pkg::PhaseShake;
              shake_start_d = now;
            end
          end
          asd_pkg::PhaseShake: begin
            if (!shaking) begin
              if ((now - shake_start_q) >= {16'd0, min_shake_ms_q}) begin
                phase_d       = asd_pkg::PhaseQuiet;
                quiet_start_d = now;
              end else begin
                phase_d = asd_pkg::PhaseIdle;
              end
            end
          end
          asd_pkg::PhaseQuiet: begin
            if ((now - quiet_start_q) >= {16'd0, quiet_ms_q}) begin
              phase_d      = asd_pkg::PhaseIdle;
              cool_stamp_d = now;
              event_d      = 1'b1;
            end
          end
          default: phase_d = asd_pkg::PhaseIdle;
        endcase
      end
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q      <= '0;
      base_y_q      <= '0;
      base_z_q      <= '0;
      valid_x_q     <= '0;
      valid_y_q     <= '0;
      valid_z_q     <= '0;
      phase_q       <= asd_pkg::PhaseIdle;
      shake_start_q <= '0;
      quiet_start_q <= '0;
      cool_stamp_q  <= '0;
      last_read_q   <= '0;
      fail_count_q  <= '0;
      dead_q        <= 1'b0;
      init_q        <= 1'b0;
    end else if (step) begin
      base_x_q      <= base_x_d;
      base_y_q      <= base_y_d;
      base_z_q      <= base_z_d;
      valid_x_q     <= valid_x_d;
      valid_y_q     <= valid_y_d;
      valid_z_q     <= valid_z_d;
      phase_q       <= phase_d;
      shake_start_q <= shake_start_d;
      quiet_start_q <= quiet_start_d;
      cool_stamp_q  <= cool_stamp_d;
      last_read_q   <= last_read_d;
      fail_count_q  <= fail_count_d;
      dead_q        <= dead_d;
      init_q        <= init_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= '{shake_event: event_d,
                 ready_res:   init_d && !dead_d,
                 filtered_x:  signed'(valid_x_d),
                 filtered_y:  signed'(valid_y_d),
                 filtered_z:  signed'(valid_z_d),
                 shake_phase: phase_d};
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.shake_event = out_q.shake_event;
  assign res_o.ready_res   = out_q.ready_res;
  assign res_o.filtered_x  = out_q.filtered_x;
  assign res_o.filtered_y  = out_q.filtered_y;
  assign res_o.filtered_z  = out_q.filtered_z;
  assign res_o.shake_phase = out_q.shake_phase;

  // Assertions
  a_dead_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> init_q)
    else $error("detector disabled before baseline load");

  a_fail_limit_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_count_q >= asd_pkg::FailLimit) |-> dead_q)
    else $error("failure limit reached without disabling");

  a_event_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.shake_event) |->
      (out_q.shake_phase == asd_pkg::PhaseIdle && out_q.ready_res))
    else $error("shake event outside idle phase");

  a_event_cooldown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && event_d) |=> (cool_stamp_q == $past(now)))
    else $error("event did not start cooldown");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the accelerometer shake detector, driver/monitor style.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 400;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxSlow} rx_mode_e;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [asd_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [asd_pkg::CfgDataW-1:0] cfg_wdata;

  asd_req_if req_if ();
  asd_res_if res_if ();

  accel_shake_detector dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // Detection requests waiting to be sent, and the results they must give.
  asd_pkg::req_t attempt_q[$];
  asd_pkg::res_t predicted_q[$];
  int unsigned n_queued;
  int unsigned n_err;
  int unsigned cycles;

  // Shadow of the configuration registers.
  logic        c_enable;
  logic [16:0] c_thresh;
  logic [15:0] c_min_shake;
  logic [15:0] c_quiet;
  logic [15:0] c_cooldown;
  logic [15:0] c_interval;

  // Shadow of the detector state.
  logic [15:0] bl_x, bl_y, bl_z;        // baseline for the deltas
  logic [15:0] good_x, good_y, good_z;  // last sample that was not a read failure
  logic [1:0]  ph;
  logic [31:0] shake_t0, quiet_t0, cool_t, read_t;
  logic [7:0]  fails;
  logic        dead;
  logic        armed;

  // Stimulus timeline and flow control.
  logic [31:0] t_ms;
  logic        send_hold;
  int unsigned hold_reqs;

  // Driver and receiver private state.
  asd_pkg::req_t drv_req;
  int unsigned burst_left, gap_left;
  int unsigned hold_seen, hold_left;
  int unsigned rx_left;
  rx_mode_e    rx_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] med3(logic signed [15:0] a, logic signed [15:0] b,
                                       logic signed [15:0] c);
    logic signed [15:0] t;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (b > c) b = c;
    if (a > b) b = a;
    return b;
  endfunction

  // |cur - prev| with the difference wrapped to 16 bits; -32768 gives 32768
  function automatic logic [16:0] mag16(logic [15:0] cur, logic [15:0] prev);
    logic [15:0] d;
    d = cur - prev;
    return d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
  endfunction

  function automatic asd_pkg::res_t detect_step(asd_pkg::req_t r);
    logic [15:0]   mx, my, mz;
    logic [17:0]   sum;
    logic          shaking;
    asd_pkg::res_t o;
    mx = med3(r.x_read_a, r.x_read_b, r.x_read_c);
    my = med3(r.y_read_a, r.y_read_b, r.y_read_c);
    mz = med3(r.z_read_a, r.z_read_b, r.z_read_c);
    o = '0;
    if (!armed) begin
      // first request after reset only loads the baseline
      bl_x = mx;
      bl_y = my;
      bl_z = mz;
      good_x = mx;
      good_y = my;
      good_z = mz;
      cool_t = '0;
      ph = asd_pkg::PhaseIdle;
      fails = '0;
      read_t = '0;
      armed = 1'b1;
    end else if (c_enable && !dead &&
                 !(cool_t != 0 && (r.now_ms - cool_t) < c_cooldown) &&
                 !(read_t != 0 && (r.now_ms - read_t) < c_interval)) begin
      read_t = r.now_ms;
      if (mx == 0 && my == 0 && mz == 0) begin
        // read failure
        if (fails != 8'hFF) fails++;
        if (fails >= asd_pkg::FailLimit) dead = 1'b1;
      end else begin
        fails = '0;
        good_x = mx;
        good_y = my;
        good_z = mz;
        sum = 18'(mag16(mx, bl_x)) + 18'(mag16(my, bl_y)) + 18'(mag16(mz, bl_z));
        bl_x = mx;
        bl_y = my;
        bl_z = mz;
        shaking = sum > c_thresh;
        case (ph)
          asd_pkg::PhaseIdle: begin
            if (shaking) begin
              ph = asd_pkg::PhaseShake;
              shake_t0 = r.now_ms;
            end
          end
          asd_pkg::PhaseShake: begin
            if (!shaking) begin
              if ((r.now_ms - shake_t0) >= c_min_shake) begin
                ph = asd_pkg::PhaseQuiet;
                quiet_t0 = r.now_ms;
              end else begin
                ph = asd_pkg::PhaseIdle;
              end
            end
          end
          asd_pkg::PhaseQuiet: begin
            if ((r.now_ms - quiet_t0) >= c_quiet) begin
              ph = asd_pkg::PhaseIdle;
              cool_t = r.now_ms;
              o.shake_event = 1'b1;
            end
          end
          default: ph = asd_pkg::PhaseIdle;
        endcase
      end
    end
    o.ready_res = armed && !dead;
    o.filtered_x = good_x;
    o.filtered_y = good_y;
    o.filtered_z = good_z;
    o.shake_phase = ph;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic asd_pkg::req_t mk_req(logic [31:0] ts,
                                  logic [15:0] xa, logic [15:0] xb, logic [15:0] xc,
                                  logic [15:0] ya, logic [15:0] yb, logic [15:0] yc,
                                  logic [15:0] za, logic [15:0] zb, logic [15:0] zc);
    asd_pkg::req_t r;
    r.now_ms = ts;
    r.x_read_a = xa;
    r.x_read_b = xb;
    r.x_read_c = xc;
    r.y_read_a = ya;
    r.y_read_b = yb;
    r.y_read_c = yc;
    r.z_read_a = za;
    r.z_read_b = zb;
    r.z_read_c = zc;
    return r;
  endfunction

  // one raw reading around v; now and then a wild outlier for the median to reject
  function automatic logic [15:0] jitter(logic [15:0] v, int unsigned jit);
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    return v + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
  endfunction

  task automatic queue_attempt(asd_pkg::req_t r);
    attempt_q.push_back(r);
    n_queued++;
  endtask

  // next sample on the timeline; some land inside the minimum read interval
  task automatic add_sample(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                            int unsigned jit);
    if ($urandom_range(0, 9) == 0) t_ms += $urandom_range(0, c_interval);
    else t_ms += c_interval + $urandom_range(0, 25);
    queue_attempt(mk_req(t_ms, jitter(vx, jit), jitter(vx, jit), jitter(vx, jit),
                         jitter(vy, jit), jitter(vy, jit), jitter(vy, jit),
                         jitter(vz, jit), jitter(vz, jit), jitter(vz, jit)));
  endtask

  // rest, a burst of swings, then rest again long enough to fire most of the time
  task automatic add_gesture();
    logic [15:0] rx, ry, rz, amp;
    int unsigned n;
    rx = 16'($urandom_range(0, 600)) - 16'd300;
    ry = 16'($urandom_range(0, 600)) - 16'd300;
    rz = 16'd16384 + 16'($urandom_range(0, 600)) - 16'd300;
    n = $urandom_range(0, 6);
    repeat (n) add_sample(rx, ry, rz, 30);
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      amp = 16'($urandom_range(800, 16000));
      if (i % 2) add_sample(rx + amp, ry - amp, rz, 200);
      else add_sample(rx - amp, ry + amp, rz + amp, 200);
    end
    if ($urandom_range(0, 5) == 0) add_sample(16'd0, 16'd0, 16'd0, 0);
    n = $urandom_range(2, 25);
    repeat (n) add_sample(rx, ry, rz, 30);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned   goal;
    int unsigned   pick;
    asd_pkg::req_t r;
    goal = n_queued + n;
    while (n_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        add_gesture();
      end else if (pick < 92) begin
        // junk readings, sometimes at an arbitrary timestamp
        r = asd_pkg::req_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             16'($urandom)});
        if ($urandom_range(0, 1)) r.now_ms = t_ms + $urandom_range(0, 60);
        queue_attempt(r);
      end else begin
        repeat ($urandom_range(1, 3)) add_sample(16'd0, 16'd0, 16'd0, 0);
      end
    end
  endtask

  // wait until every request is sent and every result is back
  task automatic drain();
    do @(posedge clk);
    while (attempt_q.size() != 0 || req_if.valid || predicted_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [asd_pkg::CfgIdxW-1:0] idx,
                           logic [asd_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      asd_pkg::CfgDetectEnable:  c_enable = val[0];
      asd_pkg::CfgShakeThresh:   c_thresh = val[16:0];
      asd_pkg::CfgMinShakeMs:    c_min_shake = val[15:0];
      asd_pkg::CfgQuietMs:       c_quiet = val[15:0];
      asd_pkg::CfgCooldownMs:    c_cooldown = val[15:0];
      asd_pkg::CfgMinIntervalMs: c_interval = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic en, logic [16:0] thr, logic [15:0] shake_ms,
                            logic [15:0] quiet, logic [15:0] cool, logic [15:0] gap);
    write_reg(asd_pkg::CfgDetectEnable, asd_pkg::CfgDataW'(en));
    write_reg(asd_pkg::CfgShakeThresh, thr);
    write_reg(asd_pkg::CfgMinShakeMs, asd_pkg::CfgDataW'(shake_ms));
    write_reg(asd_pkg::CfgQuietMs, asd_pkg::CfgDataW'(quiet));
    write_reg(asd_pkg::CfgCooldownMs, asd_pkg::CfgDataW'(cool));
    write_reg(asd_pkg::CfgMinIntervalMs, asd_pkg::CfgDataW'(gap));
  endtask

  task automatic log_mismatch(string what);
    n_err++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts with random gaps, holds valid until taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) predicted_q.push_back(detect_step(drv_req));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (attempt_q.size() != 0 && !send_hold) begin
          drv_req = attempt_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.now_ms <= drv_req.now_ms;
          req_if.x_read_a <= drv_req.x_read_a;
          req_if.x_read_b <= drv_req.x_read_b;
          req_if.x_read_c <= drv_req.x_read_c;
          req_if.y_read_a <= drv_req.y_read_a;
          req_if.y_read_b <= drv_req.y_read_b;
          req_if.y_read_c <= drv_req.y_read_c;
          req_if.z_read_a <= drv_req.z_read_a;
          req_if.z_read_b <= drv_req.z_read_b;
          req_if.z_read_c <= drv_req.z_read_c;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stretches of free flow, coin flips and heavy stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      hold_left = 0;
      rx_left = 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LongHold;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        RxOpen:  res_if.ready <= 1'b1;
        RxCoin:  res_if.ready <= 1'($urandom_range(0, 1));
        default: res_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    asd_pkg::res_t got, want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.shake_event = res_if.shake_event;
      got.ready_res = res_if.ready_res;
      got.filtered_x = res_if.filtered_x;
      got.filtered_y = res_if.filtered_y;
      got.filtered_z = res_if.filtered_z;
      got.shake_phase = res_if.shake_phase;
      if (predicted_q.size() == 0) begin
        log_mismatch("result with no request outstanding");
      end else begin
        want = predicted_q.pop_front();
        if (got.shake_event !== want.shake_event || got.ready_res !== want.ready_res ||
            got.filtered_x !== want.filtered_x || got.filtered_y !== want.filtered_y ||
            got.filtered_z !== want.filtered_z || got.shake_phase !== want.shake_phase)
          log_mismatch({$sformatf("got ev=%0b rdy=%0b x=%0d y=%0d z=%0d ph=%0d",
                                  got.shake_event, got.ready_res, got.filtered_x,
                                  got.filtered_y, got.filtered_z, got.shake_phase),
                        $sformatf(" want ev=%0b rdy=%0b x=%0d y=%0d z=%0d ph=%0d",
                                  want.shake_event, want.ready_res, want.filtered_x,
                                  want.filtered_y, want.filtered_z, want.shake_phase)});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("accel_shake_detector regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.now_ms = '0;
    req_if.x_read_a = '0;
    req_if.x_read_b = '0;
    req_if.x_read_c = '0;
    req_if.y_read_a = '0;
    req_if.y_read_b = '0;
    req_if.y_read_c = '0;
    req_if.z_read_a = '0;
    req_if.z_read_b = '0;
    req_if.z_read_c = '0;
    res_if.ready = 1'b0;
    send_hold = 1'b0;
    hold_reqs = 0;
    hold_seen = 0;
    n_queued = 0;
    n_err = 0;
    cycles = 0;
    t_ms = '0;
    // register defaults and cleared detector state
    c_enable = 1'b1;
    c_thresh = asd_pkg::ShakeThreshRst;
    c_min_shake = asd_pkg::MinShakeMsRst;
    c_quiet = asd_pkg::QuietMsRst;
    c_cooldown = asd_pkg::CooldownMsRst;
    c_interval = asd_pkg::MinIntervalMsRst;
    {bl_x, bl_y, bl_z, good_x, good_y, good_z} = '0;
    ph = asd_pkg::PhaseIdle;
    {shake_t0, quiet_t0, cool_t, read_t} = '0;
    fails = '0;
    dead = 1'b0;
    armed = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset configuration.
    // all-zero first sample still loads the baseline
    queue_attempt(mk_req(32'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // extreme readings: deltas of 32768 and 32767, starts a shake
    queue_attempt(mk_req(32'd40, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                         16'h8000, 16'h8000, 0, 16'h7FFF));
    // inside the minimum read interval: ignored
    queue_attempt(mk_req(32'd50, 100, 200, 300, 400, 500, 600, 700, 800, 900));
    // timestamp 0: wrapped difference is huge, shake long enough; stamp 0 = no read
    queue_attempt(mk_req(32'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                         16'h7FFF, 0, 0, 0));
    queue_attempt(mk_req(32'd1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                         16'h7FFF, 0, 0, 0));
    // quiet long enough: event, cooldown starts
    queue_attempt(mk_req(32'd400, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                         16'h7FFF, 0, 0, 0));
    // in cooldown: ignored
    queue_attempt(mk_req(32'd900, 5000, 6000, 7000, 5000, 6000, 7000, 1, 2, 3));
    // full-scale swing wraps to a delta of one
    queue_attempt(mk_req(32'd1400, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                         16'h8000, 0, 0, 0));
    // read failures, at most one odd reading per axis, filtered out by the median
    queue_attempt(mk_req(32'd1420, 0, 0, 5, 0, -3, 0, 0, 0, 0));
    queue_attempt(mk_req(32'd1440, 9, 0, 0, 0, 0, 0, 0, 0, 16'h8000));
    queue_attempt(mk_req(32'd1460, 0, 0, 0, 0, 0, 0, 0, 16'h7FFF, 0));
    // good read clears the failure count and starts a shake
    queue_attempt(mk_req(32'd1480, 100, 100, 100, 100, 100, 100, 16384, 16384, 16384));
    // shake too short: back to idle
    queue_attempt(mk_req(32'd1500, 100, 100, 100, 100, 100, 100, 16384, 16384, 16384));
    // median from three different orderings of the three readings
    queue_attempt(mk_req(32'd1520, 5, -7, 3, -7, 5, 3, 3, 5, -7));
    queue_attempt(mk_req(32'd1640, 3, 3, 3, 3, 3, 3, 3, 3, 3));
    // shaking while waiting for quiet is not looked at
    queue_attempt(mk_req(32'd1700, 20000, 20000, 20000, 3, 3, 3, 3, 3, 3));
    // quiet time met exactly
    queue_attempt(mk_req(32'd1940, 20000, 20000, 20000, 3, 3, 3, 3, 3, 3));
    // one ms short of the cooldown, then exactly on it
    queue_attempt(mk_req(32'd2939, 3, 3, 3, 3, 3, 3, 3, 3, 3));
    queue_attempt(mk_req(32'd2940, 3, 3, 3, 3, 3, 3, 3, 3, 3));
    t_ms = 32'd3000;
    drain();

    // Defaults, with a long result stall and a full sender pause.
    set_config(1'b1, asd_pkg::ShakeThreshRst, asd_pkg::MinShakeMsRst,
               asd_pkg::QuietMsRst, asd_pkg::CooldownMsRst, asd_pkg::MinIntervalMsRst);
    run_random(500);
    hold_reqs++;
    do @(posedge clk);
    while (attempt_q.size() > 250);
    send_hold <= 1'b1;
    do @(posedge clk);
    while (predicted_q.size() != 0 || req_if.valid);
    send_hold <= 1'b0;
    drain();

    // Threshold and time registers at their minimum.
    set_config(1'b1, 17'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(250);
    drain();

    // Time registers at their maximum, threshold at 98304, which no summed delta exceeds.
    set_config(1'b1, 17'd98304, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);
    drain();

    // Detection off.
    set_config(1'b0, 17'($urandom_range(0, 98304)), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom_range(0, 60)));
    run_random(80);
    drain();

    // Assorted mid-range settings.
    repeat (3) begin
      set_config(1'b1, 17'($urandom_range(500, 20000)), 16'($urandom_range(0, 400)),
                 16'($urandom_range(0, 800)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 60)));
      run_random(200);
      drain();
    end

    // Defaults again, timeline running through the 32-bit wrap.
    set_config(1'b1, asd_pkg::ShakeThreshRst, asd_pkg::MinShakeMsRst,
               asd_pkg::QuietMsRst, asd_pkg::CooldownMsRst, asd_pkg::MinIntervalMsRst);
    t_ms = 32'hFFFF_F800;
    run_random(200);
    drain();

    // Enough failures in a row to disable the detector, then traffic while dead.
    t_ms += 32'd70000;
    repeat (asd_pkg::FailLimit + 2) begin
      t_ms += 32'd25;
      queue_attempt(mk_req(t_ms, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    end
    run_random(60);
    drain();

    repeat (20) @(posedge clk);
    if (n_err == 0 && predicted_q.size() == 0) begin
      $display("accel_shake_detector regression: pass");
    end else begin
      $display("accel_shake_detector regression: fail");
    end
    $finish;
  end

endmodule
